// ===== sv/tt_pkg.sv =====
`timescale 1ns / 1ps
package tt_pkg;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic signed [32:0] e1x;
		logic signed [32:0] e1y;
		logic signed [32:0] e1z;
		logic signed [32:0] e2x;
		logic signed [32:0] e2y;
		logic signed [32:0] e2z;
		logic signed [24:0] du1;
		logic signed [24:0] dv1;
		logic signed [24:0] du2;
		logic signed [24:0] dv2;
	} tt_job_t;

	typedef struct packed {
		logic signed [15:0] tan_x;
		logic signed [15:0] tan_y;
		logic signed [15:0] tan_z;
		logic               degenerate;
	} tt_res_t;

endpackage

// ===== sv/tt_front.sv =====
`timescale 1ns / 1ps
module tt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	input  logic signed [23:0]   tex_u,
	input  logic signed [23:0]   tex_v,
	input  logic                 q_full,
	output logic                 job_push,
	output tt_pkg::tt_job_t      job
);
	import tt_pkg::*;

	logic [1:0]         cnt_q;
	logic signed [31:0] px_q [2];
	logic signed [31:0] py_q [2];
	logic signed [31:0] pz_q [2];
	logic signed [23:0] tu_q [2];
	logic signed [23:0] tv_q [2];
	logic               accept;
	logic               idx;

	assign full     = q_full;
	assign accept   = push && !q_full;
	assign job_push = accept && (cnt_q == 2'd2);
	assign idx      = (cnt_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			if (cnt_q == 2'd2)
				cnt_q <= 2'd0;
			else if (cnt_q == 2'd3)
				cnt_q <= 2'd1;
			else
				cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cnt_q != 2'd2) begin
			px_q[idx] <= pos_x;
			py_q[idx] <= pos_y;
			pz_q[idx] <= pos_z;
			tu_q[idx] <= tex_u;
			tv_q[idx] <= tex_v;
		end
	end

	always_comb begin
		job.e1x = 33'(px_q[1]) - 33'(px_q[0]);
		job.e1y = 33'(py_q[1]) - 33'(py_q[0]);
		job.e1z = 33'(pz_q[1]) - 33'(pz_q[0]);
		job.e2x = 33'(pos_x) - 33'(px_q[0]);
		job.e2y = 33'(pos_y) - 33'(py_q[0]);
		job.e2z = 33'(pos_z) - 33'(pz_q[0]);
		job.du1 = 25'(tu_q[1]) - 25'(tu_q[0]);
		job.dv1 = 25'(tv_q[1]) - 25'(tv_q[0]);
		job.du2 = 25'(tex_u) - 25'(tu_q[0]);
		job.dv2 = 25'(tex_v) - 25'(tv_q[0]);
	end

endmodule

// ===== sv/tt_queue.sv =====
`timescale 1ns / 1ps
module tt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  tt_pkg::tt_job_t wdata,
	output logic            q_full,
	output logic            q_valid,
	input  logic            rd,
	output tt_pkg::tt_job_t rdata
);
	import tt_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	tt_job_t      mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign q_full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && q_valid;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (do_rd)
				rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wp_q] <= wdata;
	end

endmodule

// ===== sv/tt_back.sv =====
`timescale 1ns / 1ps
module tt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	input  tt_pkg::tt_job_t job,
	output logic            job_pop,
	output tt_pkg::tt_res_t res,
	output logic            res_valid,
	input  logic            res_pop
);
	import tt_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_MAG  = 3'd2;
	localparam logic [2:0] S_SHF  = 3'd3;
	localparam logic [2:0] S_SQ   = 3'd4;
	localparam logic [2:0] S_SQRT = 3'd5;
	localparam logic [2:0] S_DIV  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0]         state_q;
	logic [4:0]         cnt_q;
	logic [1:0]         ci_q;
	tt_job_t            job_q;
	logic signed [57:0] prod_q;
	logic signed [57:0] first_q;
	logic signed [58:0] t_q [3];
	logic               det_neg_q;
	logic               det_zero_q;
	logic [57:0]        mag_q [3];
	logic [2:0]         neg_q;
	logic               deg_q;
	logic [59:0]        sq_q;
	logic [63:0]        sum_q;
	logic [63:0]        n_q;
	logic [63:0]        r_q;
	logic [63:0]        bit_q;
	logic [48:0]        rem_q;
	logic [48:0]        d_q;
	logic [16:0]        qv_q [3];
	tt_res_t            res_q;
	logic               res_v_q;

	logic signed [24:0] ma;
	logic signed [32:0] mb;
	logic signed [57:0] prod;
	logic signed [58:0] diff;
	logic [57:0]        mag_c [3];
	logic [1:0]         sq_idx;
	logic [63:0]        rb;
	logic               res_wr;
	tt_res_t            res_c;
	logic [15:0]        comp [3];
	logic [31:0]        len;

	always_comb begin
		case (cnt_q[2:0])
			3'd0: begin ma = job_q.dv2; mb = job_q.e1x; end
			3'd1: begin ma = job_q.dv1; mb = job_q.e2x; end
			3'd2: begin ma = job_q.dv2; mb = job_q.e1y; end
			3'd3: begin ma = job_q.dv1; mb = job_q.e2y; end
			3'd4: begin ma = job_q.dv2; mb = job_q.e1z; end
			3'd5: begin ma = job_q.dv1; mb = job_q.e2z; end
			3'd6: begin ma = job_q.dv2; mb = 33'(job_q.du1); end
			default: begin ma = job_q.dv1; mb = 33'(job_q.du2); end
		endcase
	end

	assign prod   = ma * mb;
	assign diff   = 59'(first_q) - 59'(prod_q);
	assign sq_idx = (cnt_q < 5'd3) ? cnt_q[1:0] : 2'd0;
	assign rb     = r_q + bit_q;
	assign len    = r_q[31:0];
	assign job_pop = (state_q == S_IDLE) && job_valid;
	assign res_wr  = (state_q == S_OUT) && (!res_v_q || res_pop);
	assign res       = res_q;
	assign res_valid = res_v_q;

	always_comb begin
		for (int i = 0; i < 3; i++)
			mag_c[i] = t_q[i][58] ? 58'(-t_q[i]) : 58'(t_q[i]);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (neg_q[i] ^ det_neg_q)
				comp[i] = (qv_q[i] > 17'd32768) ? 16'h8000 : 16'(-qv_q[i]);
			else
				comp[i] = (qv_q[i] > 17'd32767) ? 16'h7fff : qv_q[i][15:0];
		end
		if (deg_q) begin
			res_c = '0;
			res_c.degenerate = 1'b1;
		end else begin
			res_c.tan_x = comp[0];
			res_c.tan_y = comp[1];
			res_c.tan_z = comp[2];
			res_c.degenerate = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ci_q    <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (res_wr)
				res_v_q <= 1'b1;
			else if (res_pop)
				res_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						state_q <= S_MUL;
						cnt_q   <= '0;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd8)
						state_q <= S_MAG;
				end
				S_MAG: begin
					if (det_zero_q || (mag_c[0] == '0 && mag_c[1] == '0 && mag_c[2] == '0))
						state_q <= S_OUT;
					else
						state_q <= S_SHF;
				end
				S_SHF: begin
					if (mag_q[0][57:30] == '0 && mag_q[1][57:30] == '0
						&& mag_q[2][57:30] == '0) begin
						state_q <= S_SQ;
						cnt_q   <= '0;
					end
				end
				S_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd3) begin
						state_q <= S_SQRT;
						cnt_q   <= '0;
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= S_DIV;
						cnt_q   <= '0;
						ci_q    <= '0;
					end
				end
				S_DIV: begin
					if (cnt_q == 5'd17) begin
						cnt_q <= '0;
						if (ci_q == 2'd2)
							state_q <= S_OUT;
						else
							ci_q <= ci_q + 2'd1;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_OUT: begin
					if (res_wr)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_wr)
			res_q <= res_c;
		case (state_q)
			S_IDLE: begin
				if (job_valid)
					job_q <= job;
				deg_q <= 1'b0;
			end
			S_MUL: begin
				if (cnt_q < 5'd8)
					prod_q <= prod;
				if (cnt_q != 5'd0) begin
					if (!cnt_q[0]) begin
						case (cnt_q[2:1])
							2'd1: t_q[0] <= diff;
							2'd2: t_q[1] <= diff;
							2'd3: t_q[2] <= diff;
							default: begin
								det_zero_q <= (diff == '0);
								det_neg_q  <= diff[58];
							end
						endcase
					end else begin
						first_q <= prod_q;
					end
				end
			end
			S_MAG: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= mag_c[i];
					neg_q[i] <= t_q[i][58];
				end
				deg_q <= det_zero_q
					|| (mag_c[0] == '0 && mag_c[1] == '0 && mag_c[2] == '0);
			end
			S_SHF: begin
				if (!(mag_q[0][57:30] == '0 && mag_q[1][57:30] == '0
					&& mag_q[2][57:30] == '0)) begin
					for (int i = 0; i < 3; i++)
						mag_q[i] <= mag_q[i] >> 1;
				end
				sum_q <= '0;
			end
			S_SQ: begin
				sq_q <= mag_q[sq_idx][29:0] * mag_q[sq_idx][29:0];
				if (cnt_q != 5'd0)
					sum_q <= sum_q + 64'(sq_q);
				n_q   <= sum_q + 64'(sq_q);
				r_q   <= '0;
				bit_q <= 64'd1 << 62;
			end
			S_SQRT: begin
				if (n_q >= rb) begin
					n_q <= n_q - rb;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DIV: begin
				if (cnt_q == 5'd0) begin
					rem_q <= {3'b0, mag_q[ci_q][29:0], 16'b0} + 49'(len);
					d_q   <= {len, 17'b0};
					qv_q[ci_q] <= '0;
				end else begin
					if (rem_q >= d_q)
						rem_q <= rem_q - d_q;
					qv_q[ci_q] <= {qv_q[ci_q][15:0], rem_q >= d_q};
					d_q <= d_q >> 1;
				end
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> len != '0)
		else $error("divide with zero length");
	a_div_ci: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> ci_q != 2'd3)
		else $error("component index out of range");
	a_sq_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQ |-> (mag_q[0][57:30] == '0 && mag_q[1][57:30] == '0
			&& mag_q[2][57:30] == '0))
		else $error("magnitude not normalized before squaring");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && res_v_q && !res_pop) |=> state_q == S_OUT)
		else $error("result overwritten while waiting");
`endif

endmodule

// ===== sv/triangle_tangent_vector.sv =====
`timescale 1ns / 1ps
// Triangle tangent unit.
// Input queue port: push/full with pos_x/y/z (Q16.16) and tex_u/v (Q8.16);
// one item is one triangle corner. Every third corner completes a triangle.
// Result queue port: empty/pop with tan_x/y/z (Q1.15) and degenerate; one
// result per triangle, on the result ports while empty is low.
// The front holds corners 0 and 1 and forms edges and texture deltas; the
// triangle is queued (2 deep) to the back, which runs one multiplier shared
// by the cross products, a normalizing shift, squares, a bit-pair square
// root and a restoring divider per component. The back works on one triangle
// at a time while the queue holds up to two more; a degenerate triangle skips
// the shift, square, root and divide steps.
// Reset clears the corner count, the queue and the result valid flag.
// A stalled receiver holds the result register; the back then waits with
// the next result and full rises once the queue fills.
module triangle_tangent_vector (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [23:0] tex_u,
	input  logic signed [23:0] tex_v,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] tan_x,
	output logic signed [15:0] tan_y,
	output logic signed [15:0] tan_z,
	output logic               degenerate
);
	import tt_pkg::*;

	tt_job_t job_in;
	tt_job_t job_out;
	tt_res_t res;
	logic    job_push;
	logic    q_full;
	logic    q_valid;
	logic    job_pop;
	logic    res_valid;

	tt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.tex_u    (tex_u),
		.tex_v    (tex_v),
		.q_full   (q_full),
		.job_push (job_push),
		.job      (job_in)
	);

	tt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (job_push),
		.wdata   (job_in),
		.q_full  (q_full),
		.q_valid (q_valid),
		.rd      (job_pop),
		.rdata   (job_out)
	);

	tt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (job_out),
		.job_pop   (job_pop),
		.res       (res),
		.res_valid (res_valid),
		.res_pop   (pop)
	);

	assign empty      = !res_valid;
	assign tan_x      = res.tan_x;
	assign tan_y      = res.tan_y;
	assign tan_z      = res.tan_z;
	assign degenerate = res.degenerate;

endmodule
